/* hw/rtl/value_stack_with_delete_defines.svh */
// ----------------------------------------------------------------------------
// value_stack_with_delete_defines.svh
// Assertion macros shared by the value stack RTL.
// ----------------------------------------------------------------------------
`ifndef VALUE_STACK_WITH_DELETE_DEFINES_SVH
`define VALUE_STACK_WITH_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VSWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VSWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/vswd_pkg.sv */
// ----------------------------------------------------------------------------
// vswd_pkg
// Constants, codes and request/result types of the value stack.
// ----------------------------------------------------------------------------
package vswd_pkg;

	// Stack size and derived widths.
	localparam int DEPTH    = 128;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int VALUE_W  = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 7;
	localparam int FILL_W   = 8;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

	// One request.
	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	// One result.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [FILL_W-1:0]   fill;
	} res_t;

endpackage

/* hw/rtl/vswd_ram.sv */
// ----------------------------------------------------------------------------
// vswd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vswd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data appears the cycle after the address.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/value_stack_with_delete.sv */
// Push and the unused operation: result in the cycle after the request is taken.
// Find: entries are read and compared from the top down until the topmost match.
// Miss: reported once the bottom entry is compared; an empty stack answers without a search.
// Delete below the top: after the search, each entry above the match moves down one place.
// busy falls as the result appears, so the next request can be taken at the edge
// that takes the result; pushes run back to back.
// ----------------------------------------------------------------------------
// value_stack_with_delete
// Bounded stack of 32-bit values with topmost-match search and delete,
// run by a small sequencer over one dual-port RAM and one comparator.
// Reset empties the stack at once; entry contents are not cleared.
// ----------------------------------------------------------------------------
`include "value_stack_with_delete_defines.svh"

module value_stack_with_delete (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  vswd_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output vswd_pkg::res_t res
);

	localparam int AW = vswd_pkg::ADDR_W;
	localparam int CW = vswd_pkg::CNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                occ_q;
	logic [AW-1:0]                addr_q;
	logic [AW-1:0]                cmp_q;
	logic [CW-1:0]                src_q;
	logic [AW-1:0]                dst_q;
	logic                         pend_q;
	logic [vswd_pkg::VALUE_W-1:0] val_q;
	logic [vswd_pkg::FUNC_W-1:0]  func_q;
	logic                         done_q;
	vswd_pkg::res_t               res_q;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [vswd_pkg::VALUE_W-1:0] ram_wdata;
	logic                         ram_re;
	logic [AW-1:0]                ram_raddr;
	logic [vswd_pkg::VALUE_W-1:0] ram_rdata;
	logic                         hit;
	logic                         accept;

	assign accept = start && (state_q == S_IDLE);
	assign hit    = pend_q && (ram_rdata == val_q);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign res    = res_q;

	// Entry storage.
	vswd_ram #(
		.WIDTH(vswd_pkg::VALUE_W),
		.DEPTH(vswd_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// RAM port control for each sequencer state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = occ_q[AW-1:0];
		ram_wdata = req.value;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		case (state_q)
			S_IDLE: begin
				ram_we = accept && (req.func == vswd_pkg::FUNC_PUSH) &&
					(occ_q < CW'(vswd_pkg::DEPTH));
			end
			S_SEARCH: begin
				ram_re = 1'b1;
			end
			S_SHIFT: begin
				ram_re    = (src_q < occ_q);
				ram_raddr = src_q[AW-1:0];
				ram_we    = pend_q;
				ram_waddr = dst_q;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer, count and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					pend_q <= 1'b0;
					if (accept) begin
						val_q  <= req.value;
						func_q <= req.func;
						addr_q <= AW'(occ_q - CW'(1));
						if (req.func == vswd_pkg::FUNC_PUSH) begin
							done_q            <= 1'b1;
							res_q.position    <= '0;
							if (occ_q < CW'(vswd_pkg::DEPTH)) begin
								occ_q        <= occ_q + CW'(1);
								res_q.status <= vswd_pkg::STATUS_OK;
								res_q.fill   <= vswd_pkg::FILL_W'(occ_q + CW'(1));
							end else begin
								res_q.status <= vswd_pkg::STATUS_FULL;
								res_q.fill   <= vswd_pkg::FILL_W'(occ_q);
							end
						end else if (req.func == vswd_pkg::FUNC_DELETE ||
							req.func == vswd_pkg::FUNC_FIND) begin
							if (occ_q == '0) begin
								done_q         <= 1'b1;
								res_q.status   <= vswd_pkg::STATUS_MISSING;
								res_q.position <= '0;
								res_q.fill     <= vswd_pkg::FILL_W'(occ_q);
							end else begin
								state_q <= S_SEARCH;
							end
						end else begin
							done_q         <= 1'b1;
							res_q.status   <= vswd_pkg::STATUS_OK;
							res_q.position <= '0;
							res_q.fill     <= vswd_pkg::FILL_W'(occ_q);
						end
					end
				end
				S_SEARCH: begin
					// Compare the entry read last cycle while reading the next one down.
					if (hit) begin
						pend_q <= 1'b0;
						if (func_q == vswd_pkg::FUNC_FIND) begin
							done_q         <= 1'b1;
							res_q.status   <= vswd_pkg::STATUS_OK;
							res_q.position <= vswd_pkg::POS_W'(cmp_q);
							res_q.fill     <= vswd_pkg::FILL_W'(occ_q);
							state_q        <= S_IDLE;
						end else if (CW'(cmp_q) == occ_q - CW'(1)) begin
							occ_q          <= occ_q - CW'(1);
							done_q         <= 1'b1;
							res_q.status   <= vswd_pkg::STATUS_OK;
							res_q.position <= vswd_pkg::POS_W'(cmp_q);
							res_q.fill     <= vswd_pkg::FILL_W'(occ_q - CW'(1));
							state_q        <= S_IDLE;
						end else begin
							src_q   <= CW'(cmp_q) + CW'(1);
							state_q <= S_SHIFT;
						end
					end else if (pend_q && cmp_q == '0) begin
						pend_q         <= 1'b0;
						done_q         <= 1'b1;
						res_q.status   <= vswd_pkg::STATUS_MISSING;
						res_q.position <= '0;
						res_q.fill     <= vswd_pkg::FILL_W'(occ_q);
						state_q        <= S_IDLE;
					end else begin
						pend_q <= 1'b1;
						cmp_q  <= addr_q;
						addr_q <= addr_q - AW'(1);
					end
				end
				S_SHIFT: begin
					// Read entry src, write it one place lower the next cycle.
					if (src_q < occ_q) begin
						pend_q <= 1'b1;
						dst_q  <= AW'(src_q - CW'(1));
						src_q  <= src_q + CW'(1);
					end else begin
						pend_q         <= 1'b0;
						occ_q          <= occ_q - CW'(1);
						done_q         <= 1'b1;
						res_q.status   <= vswd_pkg::STATUS_OK;
						res_q.position <= vswd_pkg::POS_W'(cmp_q);
						res_q.fill     <= vswd_pkg::FILL_W'(occ_q - CW'(1));
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The count never exceeds the stack size.
	`VSWD_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1,
		occ_q <= CW'(vswd_pkg::DEPTH), "count overflow")
	// Push and the unused operation answer in the following cycle.
	`VSWD_ASSERT_NEXT(a_quick_done, clk, arst_n,
		start && !busy && req.func != vswd_pkg::FUNC_DELETE &&
		req.func != vswd_pkg::FUNC_FIND,
		done && !busy, "missing quick result")
	// A failed search reports no position.
	`VSWD_ASSERT_NOW(a_miss_pos, clk, arst_n,
		done && res.status == vswd_pkg::STATUS_MISSING,
		res.position == '0, "position on miss")
	// Moving entries down only happens below the top of the stack.
	`VSWD_ASSERT_NOW(a_shift_range, clk, arst_n, state_q == S_SHIFT,
		CW'(cmp_q) + CW'(1) < occ_q + CW'(1) && occ_q != '0, "shift out of range")

endmodule
